// ===== rtl/core/conv2d_valid_8x8_int32_defines.svh =====
// assertion macros for the 2d convolution block
`ifndef CONV2D_VALID_8X8_INT32_DEFINES_SVH
`define CONV2D_VALID_8X8_INT32_DEFINES_SVH

`ifndef SYNTHESIS
`define C2D_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define C2D_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define C2D_ASSERT(label, prop, msg)
`define C2D_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

// ===== rtl/core/c2d_pkg.sv =====
// shared constants and types for the 2d convolution block
package c2d_pkg;
  localparam int KS       = 8;
  localparam int KTAPS    = KS * KS;
  localparam int LINES    = KS - 1;
  localparam int MAX_COLS = 1024;
  localparam int MAX_ROWS = 1024;
  localparam int COL_W    = 10;
  localparam int DIM_W    = 11;
  localparam int IDX_W    = 6;
  localparam int LINE_W   = 32 * LINES;

  localparam logic       REG_COLS   = 1'b0;
  localparam logic       REG_ROWS   = 1'b1;
  localparam logic       KIND_COEF  = 1'b0;
  localparam logic       KIND_PIXEL = 1'b1;

  typedef logic [31:0] word_t;
  typedef word_t [KTAPS-1:0] taps_t;

  typedef struct packed {
    logic [COL_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             last;
  } meta_t;
endpackage

// ===== rtl/core/c2d_ram.sv =====
// generic simple dual-port ram with registered read
module c2d_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end
endmodule

// ===== rtl/core/c2d_mac.sv =====
// multiply stage, registered adder tree and output register
module c2d_mac import c2d_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  win_valid,
  output logic  win_take,
  input  taps_t win,
  input  taps_t coef,
  input  meta_t win_meta,
  output logic  out_valid,
  input  logic  out_stall,
  output word_t sum,
  output meta_t out_meta
);
  taps_t    prod;
  meta_t    p_meta, g_meta;
  word_t    grp [KS];
  logic     pv, gv;
  logic     adv_o, adv_g;
  word_t    grp_next [KS];
  word_t    total_next;

  assign adv_o    = !out_valid || !out_stall;
  assign adv_g    = !gv || adv_o;
  assign win_take = !pv || adv_g;

  always_comb begin
    for (int i = 0; i < KS; i++) begin
      grp_next[i] = '0;
      for (int j = 0; j < KS; j++) begin
        grp_next[i] = grp_next[i] + prod[i*KS+j];
      end
    end
    total_next = '0;
    for (int i = 0; i < KS; i++) begin
      total_next = total_next + grp[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pv        <= 1'b0;
      gv        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (win_take) pv <= win_valid;
      if (adv_g) gv <= pv;
      if (adv_o) out_valid <= gv;
    end
    if (win_take) begin
      // low half of each product is all that the wrapping sum needs
      for (int k = 0; k < KTAPS; k++) begin
        prod[k] <= win[k] * coef[k];
      end
      p_meta <= win_meta;
    end
    if (adv_g) begin
      for (int i = 0; i < KS; i++) begin
        grp[i] <= grp_next[i];
      end
      g_meta <= p_meta;
    end
    if (adv_o) begin
      sum      <= total_next;
      out_meta <= g_meta;
    end
  end
endmodule

// ===== rtl/core/conv2d_valid_8x8_int32.sv =====
// top level: pixel counters, line store, window and coefficient registers
// Streaming 8x8 valid-region correlation. While in_stall is low one item
// is taken every clock cycle, coefficient loads and pixels alike. The seven
// line buffers live in one 224-bit wide, 1024-deep dual-port RAM indexed by
// column: each pixel reads its column on the accept edge and writes the
// shifted column back as it leaves the stage register, so one read and one
// write port set the rate of one item per cycle. A result then passes the
// window, the 64 multipliers and a two-level registered adder tree.
// Coefficient loads share the stage register, so they apply in item order.
module conv2d_valid_8x8_int32 import c2d_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [10:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        kind,
  input  logic [5:0]  coef_index,
  input  logic [31:0] coef_value,
  input  logic [31:0] pixel,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] sum,
  output logic [9:0]  out_row,
  output logic [9:0]  out_col,
  output logic        frame_end
);
  `include "conv2d_valid_8x8_int32_defines.svh"

  logic [DIM_W-1:0] cols_cfg, rows_cfg, cols_eff, rows_eff;
  logic [COL_W-1:0] pixel_row, pixel_col;
  logic             row_end, frame_last, has_res, in_acc;

  logic             s1v, s1_kind, s1_res;
  logic [IDX_W-1:0] s1_cidx;
  word_t            s1_cval, s1_px;
  logic [COL_W-1:0] s1_c;
  meta_t            s1_meta, w_meta, o_meta;
  logic             s1_take, adv_w, w_take, wv;

  logic             rd_en, wr_en;
  logic [LINE_W-1:0] rd_data, wr_data;
  word_t            column [KS];
  word_t            win [KS][KS];
  taps_t            win_flat, coef;

  assign cfg_ready = 1'b1;

  always_comb begin
    if (cols_cfg < DIM_W'(KS)) cols_eff = DIM_W'(KS);
    else if (cols_cfg > DIM_W'(MAX_COLS)) cols_eff = DIM_W'(MAX_COLS);
    else cols_eff = cols_cfg;
    if (rows_cfg < DIM_W'(KS)) rows_eff = DIM_W'(KS);
    else if (rows_cfg > DIM_W'(MAX_ROWS)) rows_eff = DIM_W'(MAX_ROWS);
    else rows_eff = rows_cfg;
  end

  assign row_end    = ({1'b0, pixel_col} + DIM_W'(1)) >= cols_eff;
  assign frame_last = row_end && (({1'b0, pixel_row} + DIM_W'(1)) >= rows_eff);
  assign has_res    = (pixel_row >= COL_W'(KS-1)) && (pixel_col >= COL_W'(KS-1));

  assign adv_w    = !wv || w_take;
  assign in_stall = s1v && !adv_w;
  assign in_acc   = in_valid && !in_stall;
  assign s1_take  = s1v && adv_w;

  assign rd_en   = in_acc && (kind == KIND_PIXEL);
  assign wr_en   = s1_take && (s1_kind == KIND_PIXEL);

  always_comb begin
    for (int i = 0; i < LINES; i++) begin
      column[i] = rd_data[32*i +: 32];
    end
    column[KS-1] = s1_px;
    // every line moves up one, the new pixel enters the bottom line
    for (int i = 0; i < LINES; i++) begin
      wr_data[32*i +: 32] = column[i+1];
    end
    for (int i = 0; i < KS; i++) begin
      for (int j = 0; j < KS; j++) begin
        win_flat[i*KS+j] = win[i][j];
      end
    end
  end

  c2d_ram #(.WIDTH(LINE_W), .DEPTH(MAX_COLS)) u_lines (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (s1_c),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (pixel_col),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cols_cfg   <= DIM_W'(MAX_COLS);
      rows_cfg   <= DIM_W'(MAX_ROWS);
      pixel_row  <= '0;
      pixel_col  <= '0;
      s1v        <= 1'b0;
      wv         <= 1'b0;
      coef       <= '0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_COLS: cols_cfg <= cfg_data;
          REG_ROWS: rows_cfg <= cfg_data;
          default:  cols_cfg <= cols_cfg;
        endcase
      end
      if (in_acc && (kind == KIND_PIXEL)) begin
        priority if (frame_last) begin
          pixel_row <= '0;
          pixel_col <= '0;
        end else if (row_end) begin
          pixel_col <= '0;
          pixel_row <= pixel_row + COL_W'(1);
        end else begin
          pixel_col <= pixel_col + COL_W'(1);
        end
      end
      if (in_acc) s1v <= 1'b1;
      else if (s1_take) s1v <= 1'b0;
      if (s1_take && (s1_kind == KIND_PIXEL)) wv <= s1_res;
      else if (w_take) wv <= 1'b0;
      if (s1_take && (s1_kind == KIND_COEF)) coef[s1_cidx] <= s1_cval;
    end
    if (in_acc) begin
      s1_kind      <= kind;
      s1_cidx      <= coef_index;
      s1_cval      <= coef_value;
      s1_px        <= pixel;
      s1_c         <= pixel_col;
      s1_res       <= has_res;
      s1_meta.row  <= pixel_row - COL_W'(KS-1);
      s1_meta.col  <= pixel_col - COL_W'(KS-1);
      s1_meta.last <= frame_last;
    end
    if (s1_take && (s1_kind == KIND_PIXEL)) begin
      for (int i = 0; i < KS; i++) begin
        for (int j = 0; j < KS-1; j++) begin
          win[i][j] <= win[i][j+1];
        end
        win[i][KS-1] <= column[i];
      end
      w_meta <= s1_meta;
    end
  end

  c2d_mac u_mac (
    .clk       (clk),
    .rst       (rst),
    .win_valid (wv),
    .win_take  (w_take),
    .win       (win_flat),
    .coef      (coef),
    .win_meta  (w_meta),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sum       (sum),
    .out_meta  (o_meta)
  );

  assign out_row   = o_meta.row;
  assign out_col   = o_meta.col;
  assign frame_end = o_meta.last;

  `C2D_ASSERT(a_no_same_entry, !(rd_en && wr_en && (pixel_col == s1_c)), "line store collision")
  `C2D_ASSERT(a_win_hold, (wv && !w_take) |=> (wv && $stable(win_flat)), "window changed")
  `C2D_ASSERT(a_frame_wrap, (rd_en && frame_last) |=> ({pixel_row, pixel_col} == '0), "no wrap")
  `C2D_ASSERT(a_stage_full, in_acc |=> s1v, "accepted item lost")
endmodule
